### rtl/core/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg: shared constants for the escape count colormap
// Register indexes, reset values, port widths and channel scale factors.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Port widths fixed by the pixel format
  localparam int COUNT_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CHANNEL_W   = 8;

  // Register map
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_MODE    = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] MAX_ITERATIONS_RESET = 16'd255;

  // Linear mode splits a 24-bit fraction into three bytes
  localparam int LINEAR_BITS = 24;

  // Smooth mode channel weights, times 255 (blue weight carries an extra halving)
  localparam int SCALE_W = 13;
  localparam logic [SCALE_W-1:0] RED_SCALE   = 13'd2295;
  localparam logic [SCALE_W-1:0] GREEN_SCALE = 13'd3825;
  localparam logic [SCALE_W-1:0] BLUE_SCALE  = 13'd4335;

endpackage

### rtl/core/ecc_div_cell.sv
// ----------------------------------------------------------------------------
// ecc_div_cell: one quotient bit of the count/limit fraction
// Shifts the partial remainder, subtracts the limit when it fits, and hands
// remainder and quotient bits to the next cell every cycle.
// ----------------------------------------------------------------------------
module ecc_div_cell #(
  parameter int CNT_W         = 16,
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CNT_W-1:0]         lim,
  input  logic                     in_valid,
  input  logic [CNT_W-1:0]         in_rem,
  input  logic [FRACTION_BITS-1:0] in_quo,
  input  logic                     in_full,
  output logic                     out_valid,
  output logic [CNT_W-1:0]         out_rem,
  output logic [FRACTION_BITS-1:0] out_quo,
  output logic                     out_full
);

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             take;
  logic [CNT_W-1:0] rem_next;

  // Trial subtract of the limit from the doubled remainder
  always_comb begin
    shifted  = {in_rem, 1'b0};
    diff     = shifted - {1'b0, lim};
    take     = (shifted >= {1'b0, lim});
    rem_next = take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
  end

  // Advance the request state to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= rem_next;
    out_quo  <= {in_quo[FRACTION_BITS-2:0], take};
    out_full <= in_full;
  end

endmodule

### rtl/core/ecc_color.sv
// ----------------------------------------------------------------------------
// ecc_color: fraction to RGB bytes
// Three multiply stages build the truncated Bernstein products of t and 1-t;
// the last stage scales them or splits t into linear digits and registers RGB.
// ----------------------------------------------------------------------------
module ecc_color #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                smooth,
  input  logic                                in_valid,
  input  logic [FRACTION_BITS:0]              in_t,
  output logic                                done,
  output logic [ecc_pkg::CHANNEL_W-1:0]       red,
  output logic [ecc_pkg::CHANNEL_W-1:0]       green,
  output logic [ecc_pkg::CHANNEL_W-1:0]       blue
);

  localparam int F      = FRACTION_BITS;
  localparam int PROD_W = 2 * F + 2;
  localparam int SC_W   = F + 1 + ecc_pkg::SCALE_W;
  localparam int SHIFT  = F - ecc_pkg::LINEAR_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Stage 1: u*t and u*u
  logic [F:0]        u_in;
  logic [PROD_W-1:0] p_ut;
  logic [PROD_W-1:0] p_uu;
  logic              valid1;
  logic [F:0]        t1;
  logic [F:0]        u1;
  logic [F:0]        ut1;
  logic [F:0]        uu1;

  always_comb begin
    u_in = ONE - in_t;
    p_ut = u_in * in_t;
    p_uu = u_in * u_in;
  end

  always_ff @(posedge clk) begin
    t1  <= in_t;
    u1  <= u_in;
    ut1 <= p_ut[2*F:F];
    uu1 <= p_uu[2*F:F];
  end

  // Stage 2: u*t*t, u*u*t, u*u*u
  logic [PROD_W-1:0] p_utt;
  logic [PROD_W-1:0] p_uut;
  logic [PROD_W-1:0] p_uuu;
  logic              valid2;
  logic [F:0]        t2;
  logic [F:0]        utt2;
  logic [F:0]        uut2;
  logic [F:0]        uuu2;

  always_comb begin
    p_utt = ut1 * t1;
    p_uut = uu1 * t1;
    p_uuu = uu1 * u1;
  end

  always_ff @(posedge clk) begin
    t2   <= t1;
    utt2 <= p_utt[2*F:F];
    uut2 <= p_uut[2*F:F];
    uuu2 <= p_uuu[2*F:F];
  end

  // Stage 3: final factor of t on each channel
  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_g;
  logic [PROD_W-1:0] p_b;
  logic              valid3;
  logic [F:0]        t3;
  logic [F:0]        pr3;
  logic [F:0]        pg3;
  logic [F:0]        pb3;

  always_comb begin
    p_r = utt2 * t2;
    p_g = uut2 * t2;
    p_b = uuu2 * t2;
  end

  always_ff @(posedge clk) begin
    t3  <= t2;
    pr3 <= p_r[2*F:F];
    pg3 <= p_g[2*F:F];
    pb3 <= p_b[2*F:F];
  end

  // Stage 4: scale or split into digits, then register the result
  logic [SC_W-1:0] s_r;
  logic [SC_W-1:0] s_g;
  logic [SC_W-1:0] s_b;
  logic [F:0]      lin;
  logic [ecc_pkg::CHANNEL_W-1:0] red_next;
  logic [ecc_pkg::CHANNEL_W-1:0] green_next;
  logic [ecc_pkg::CHANNEL_W-1:0] blue_next;

  always_comb begin
    s_r = pr3 * ecc_pkg::RED_SCALE;
    s_g = pg3 * ecc_pkg::GREEN_SCALE;
    s_b = pb3 * ecc_pkg::BLUE_SCALE;
    lin = t3 >> SHIFT;
    if (smooth) begin
      red_next   = s_r[F+7:F];
      green_next = s_g[F+7:F];
      blue_next  = s_b[F+8:F+1];
    end else begin
      // a full count wraps to zero in every digit
      blue_next  = lin[23:16];
      red_next   = lin[15:8];
      green_next = lin[7:0];
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // Advance the valid marks down the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= in_valid;
      valid2 <= valid1;
      valid3 <= valid2;
      done   <= valid3;
    end
  end

endmodule

### rtl/core/escape_count_colormap_core.sv
// ----------------------------------------------------------------------------
// escape_count_colormap_core: escape iteration count to RGB pixel color
// Pipeline from start to done:
//   one clamp stage, one divider cell per fraction bit, four color stages.
// Throughput: one request per cycle; busy is high only during reset.
// Reset: synchronous; clears all valid marks, max_iterations to 255,
//   smooth_mode to linear. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module escape_count_colormap_core #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ecc_pkg::COUNT_W-1:0]       iteration_count,
  input  logic                              cfg_write,
  input  logic [ecc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ecc_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic [ecc_pkg::CHANNEL_W-1:0]     red,
  output logic [ecc_pkg::CHANNEL_W-1:0]     green,
  output logic [ecc_pkg::CHANNEL_W-1:0]     blue
);

  localparam int CNT_W = (COUNT_BITS < ecc_pkg::COUNT_W) ? COUNT_BITS : ecc_pkg::COUNT_W;
  localparam int F     = FRACTION_BITS;

  // Configuration registers
  logic [ecc_pkg::CFG_W-1:0] max_iterations;
  logic                      smooth_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= ecc_pkg::MAX_ITERATIONS_RESET;
      smooth_mode    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ecc_pkg::REG_MAX_ITERATIONS: max_iterations <= cfg_data;
        ecc_pkg::REG_SMOOTH_MODE:    smooth_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Effective limit: zero counts as one
  logic [CNT_W-1:0] lim_raw;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  always_comb begin
    lim_raw = max_iterations[CNT_W-1:0];
    lim     = (lim_raw == '0) ? CNT_W'(1) : lim_raw;
    cnt     = iteration_count[CNT_W-1:0];
    accept  = start && !busy;
  end

  // Clamp stage: a count at or above the limit gives the full fraction
  logic             valid0;
  logic [CNT_W-1:0] rem0;
  logic             full0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    full0 <= (cnt >= lim);
    rem0  <= (cnt >= lim) ? '0 : cnt;
  end

  // Divider chain: one cell per fraction bit
  logic             valid_c [0:F];
  logic [CNT_W-1:0] rem_c   [0:F];
  logic [F-1:0]     quo_c   [0:F];
  logic             full_c  [0:F];

  assign valid_c[0] = valid0;
  assign rem_c[0]   = rem0;
  assign quo_c[0]   = '0;
  assign full_c[0]  = full0;

  for (genvar i = 0; i < F; i++) begin : g_cell
    ecc_div_cell #(
      .CNT_W         (CNT_W),
      .FRACTION_BITS (F)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .lim       (lim),
      .in_valid  (valid_c[i]),
      .in_rem    (rem_c[i]),
      .in_quo    (quo_c[i]),
      .in_full   (full_c[i]),
      .out_valid (valid_c[i+1]),
      .out_rem   (rem_c[i+1]),
      .out_quo   (quo_c[i+1]),
      .out_full  (full_c[i+1])
    );
  end

  // Fraction t in Q1.F, exactly one for a full count
  logic [F:0] t_frac;

  assign t_frac = full_c[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo_c[F]};

  ecc_color #(
    .FRACTION_BITS (F)
  ) u_color (
    .clk      (clk),
    .rst      (rst),
    .smooth   (smooth_mode),
    .in_valid (valid_c[F]),
    .in_t     (t_frac),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

### verif/tb_escape_count_colormap_core.sv
// ----------------------------------------------------------------------------
// tb_escape_count_colormap_core: self-checking bench for the colormap core
// Walks a short table of directed pixels and register writes, then runs
// random phases of counts under varied limits and both coloring modes. Every
// accepted pixel is colored by the table or an in-bench predictor and matched against done.
// ----------------------------------------------------------------------------
module tb_escape_count_colormap_core;

  localparam int FRAC_BITS     = 24;
  localparam int LATENCY       = FRAC_BITS + 5;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_PIXELS  = 90;
  localparam int LIMIT_CYCLES  = 200000;

  // Spare register indexes: writes there must leave the core unchanged
  localparam logic [ecc_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [ecc_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [ecc_pkg::CHANNEL_W-1:0] red;
    logic [ecc_pkg::CHANNEL_W-1:0] green;
    logic [ecc_pkg::CHANNEL_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [ecc_pkg::COUNT_W-1:0] count;
    color_t                      color;
  } pixel_due_t;

  typedef enum logic [2:0] {
    STEP_PIXEL,
    STEP_SET_MAX,
    STEP_SET_SMOOTH,
    STEP_SET_SPARE2,
    STEP_SET_SPARE3
  } step_kind_t;

  // One row: a pixel (value is the count) or a register write (value is data)
  typedef struct packed {
    step_kind_t                kind;
    logic [ecc_pkg::CFG_W-1:0] value;
    logic                      typed;
    color_t                    color;
  } step_t;

  localparam int NUM_STEPS = 32;
  localparam step_t DIRECTED_STEPS [0:NUM_STEPS-1] = '{
    // reset settings: limit 255, linear split
    '{STEP_PIXEL,      16'd0,     1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd255,   1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'hFFFF,  1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd1,     1'b1, '{8'h01,   8'h01,   8'h01}},
    '{STEP_PIXEL,      16'd128,   1'b0, '{8'd0,    8'd0,    8'd0}},
    // half way lands entirely in the top digit
    '{STEP_SET_MAX,    16'd2,     1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd1,     1'b1, '{8'h00,   8'h00,   8'h80}},
    '{STEP_PIXEL,      16'd2,     1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_SET_MAX,    16'd3,     1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd1,     1'b1, '{8'h55,   8'h55,   8'h55}},
    // zero limit behaves as a limit of one
    '{STEP_SET_MAX,    16'd0,     1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd0,     1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'hFFFF,  1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_SET_MAX,    16'hFFFF,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'hFFFF,  1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'h8000,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'h0001,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'hAAAA,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'h5555,  1'b0, '{8'd0,    8'd0,    8'd0}},
    // smooth polynomials: both ends are black
    '{STEP_SET_SMOOTH, 16'h0001,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd0,     1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'hFFFF,  1'b1, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd21845, 1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_SET_MAX,    16'd2,     1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd1,     1'b1, '{8'd143,  8'd239,  8'd135}},
    '{STEP_PIXEL,      16'd7,     1'b1, '{8'd0,    8'd0,    8'd0}},
    // spare indexes change nothing
    '{STEP_SET_SPARE2, 16'hFFFF,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_SET_SPARE3, 16'h0000,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd1,     1'b1, '{8'd143,  8'd239,  8'd135}},
    '{STEP_SET_MAX,    16'd255,   1'b0, '{8'd0,    8'd0,    8'd0}},
    // upper data bits do not reach the mode flag
    '{STEP_SET_SMOOTH, 16'hFFFE,  1'b0, '{8'd0,    8'd0,    8'd0}},
    '{STEP_PIXEL,      16'd100,   1'b0, '{8'd0,    8'd0,    8'd0}}
  };

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [ecc_pkg::COUNT_W-1:0]       iteration_count;
  logic                              cfg_write;
  logic [ecc_pkg::CFG_INDEX_W-1:0]   cfg_index;
  logic [ecc_pkg::CFG_W-1:0]         cfg_data;
  logic                              done;
  logic [ecc_pkg::CHANNEL_W-1:0]     red;
  logic [ecc_pkg::CHANNEL_W-1:0]     green;
  logic [ecc_pkg::CHANNEL_W-1:0]     blue;

  // Shadow copies of the core's registers
  logic [ecc_pkg::CFG_W-1:0]         shadow_max_iter;
  logic                              shadow_smooth;

  pixel_due_t colors_due[$];
  int         mismatch_count;
  int         pixels_checked;
  int         pixels_linear;
  int         pixels_smooth;
  int         cycle_count;

  escape_count_colormap_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .iteration_count (iteration_count),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .red             (red),
    .green           (green),
    .blue            (blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncating product of two Q1.24 fractions in [0, 1]
  function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] one;
    one = 64'd1 << FRAC_BITS;
    if (a >= one) return b;
    if (b >= one) return a;
    return (a * b) >> FRAC_BITS;
  endfunction

  // Color of one pixel under the shadow register settings
  function automatic color_t pixel_color(input logic [ecc_pkg::COUNT_W-1:0] count);
    logic [63:0] lim;
    logic [63:0] cnt;
    logic [63:0] frac;
    logic [63:0] rest;
    logic [63:0] pr;
    logic [63:0] pg;
    logic [63:0] pb;
    color_t      c;
    lim = 64'(shadow_max_iter);
    if (lim == 0) lim = 1;
    cnt = 64'(count);
    if (cnt > lim) cnt = lim;
    frac = (cnt << FRAC_BITS) / lim;
    if (!shadow_smooth) begin
      c.blue  = frac[23:16];
      c.red   = frac[15:8];
      c.green = frac[7:0];
    end else begin
      rest = (64'd1 << FRAC_BITS) - frac;
      pr = frac_mul(frac_mul(frac_mul(rest, frac), frac), frac);
      pg = frac_mul(frac_mul(frac_mul(rest, rest), frac), frac);
      pb = frac_mul(frac_mul(frac_mul(rest, rest), rest), frac);
      c.red   = 8'((pr * 64'(ecc_pkg::RED_SCALE)) >> FRAC_BITS);
      c.green = 8'((pg * 64'(ecc_pkg::GREEN_SCALE)) >> FRAC_BITS);
      c.blue  = 8'((pb * 64'(ecc_pkg::BLUE_SCALE)) >> (FRAC_BITS + 1));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Present one pixel request and hold it until the core takes it
  task automatic send_pixel(input logic [ecc_pkg::COUNT_W-1:0] count, input logic typed,
                            input color_t typed_color);
    pixel_due_t due;
    @(negedge clk);
    start           <= 1'b1;
    iteration_count <= count;
    do @(posedge clk); while (busy);
    due.count = count;
    due.color = typed ? typed_color : pixel_color(count);
    colors_due.push_back(due);
    if (shadow_smooth) pixels_smooth++;
    else pixels_linear++;
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_burst(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop start and wait until every outstanding pixel has come back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ecc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ecc_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      ecc_pkg::REG_MAX_ITERATIONS: shadow_max_iter = data;
      ecc_pkg::REG_SMOOTH_MODE:    shadow_smooth   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Pick a count that stresses the clamp and both ends of the fraction
  function automatic logic [ecc_pkg::COUNT_W-1:0] pick_count;
    logic [ecc_pkg::COUNT_W:0] lim;
    lim = (shadow_max_iter == 0) ? 17'd1 : 17'(shadow_max_iter);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim[ecc_pkg::COUNT_W-1:0];
      2:       return (lim == 17'hFFFF) ? 16'hFFFF : 16'(lim + 1);
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom);
      default: return 16'($urandom_range(0, int'(lim)));
    endcase
  endfunction

  function automatic logic [ecc_pkg::CFG_W-1:0] pick_limit(input int phase);
    if (phase == 0) return '0;
    if (phase == 1) return 16'hFFFF;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(2, 16));
      4:       return 16'($urandom_range(17, 1023));
      5:       return 16'($urandom);
      6:       return 16'd255;
      default: return 16'($urandom_range(1024, 65535));
    endcase
  endfunction

  // Match each done strobe against the oldest outstanding pixel
  always @(posedge clk) begin
    pixel_due_t due;
    if (!rst && done) begin
      if (colors_due.size() == 0) begin
        report_mismatch($sformatf("result %0h/%0h/%0h with no request waiting",
                                  red, green, blue));
      end else begin
        due = colors_due.pop_front();
        pixels_checked++;
        if (red !== due.color.red)
          report_mismatch($sformatf("count %0d red %0d, want %0d",
                                    due.count, red, due.color.red));
        if (green !== due.color.green)
          report_mismatch($sformatf("count %0d green %0d, want %0d",
                                    due.count, green, due.color.green));
        if (blue !== due.color.blue)
          report_mismatch($sformatf("count %0d blue %0d, want %0d",
                                    due.count, blue, due.color.blue));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, colors_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic gaps_on;
    step_t step;
    rst             = 1'b1;
    start           = 1'b0;
    iteration_count = '0;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    shadow_max_iter = ecc_pkg::MAX_ITERATIONS_RESET;
    shadow_smooth   = 1'b0;
    pixels_linear   = 0;
    pixels_smooth   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_STEPS; i++) begin
      step = DIRECTED_STEPS[i];
      case (step.kind)
        STEP_PIXEL: send_pixel(step.value, step.typed, step.color);
        default: begin
          drain();
          case (step.kind)
            STEP_SET_MAX:    write_reg(ecc_pkg::REG_MAX_ITERATIONS, step.value);
            STEP_SET_SMOOTH: write_reg(ecc_pkg::REG_SMOOTH_MODE, step.value);
            STEP_SET_SPARE2: write_reg(REG_SPARE_2, step.value);
            default:         write_reg(REG_SPARE_3, step.value);
          endcase
        end
      endcase
    end

    // Random phases: new settings each phase, no gaps in the last two
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(ecc_pkg::REG_MAX_ITERATIONS, pick_limit(p));
      write_reg(ecc_pkg::REG_SMOOTH_MODE, {15'($urandom), p[0]});
      gaps_on = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(pick_count(), 1'b0, '0);
        if (p == 4 && n == PHASE_PIXELS / 2) drain();
        else if (gaps_on && $urandom_range(0, 7) == 0) idle_burst($urandom_range(1, 13));
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d pixels: %0d linear, %0d smooth.",
             pixels_checked, pixels_linear, pixels_smooth);
    $display("Covered directed corners plus %0d random limit phases, gapped and back to back.",
             NUM_PHASES);
    if (mismatch_count == 0 && colors_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels never returned", mismatch_count, colors_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
